FILE: rtl/core/wbss_pkg.sv
// Package for the wildcard byte signature scanner: register indexes,
// shared types and the per-position compare used by the window cells.
// No dependencies.
package wbss_pkg;

  // Signature storage and result widths
  localparam int SIG_BYTES       = 16;
  localparam int SIG_BITS        = SIG_BYTES * 8;
  localparam int LEN_BITS        = 5;
  localparam int ADDR_BITS       = 64;
  localparam int RES_DATA_BITS   = 72;
  localparam int DEF_MAX_PATTERN = 16;
  localparam int DEF_OFFSET_BITS = 32;

  // Configuration register indexes
  typedef enum logic [2:0] {
    REG_PATTERN_LOW    = 3'd0,
    REG_PATTERN_HIGH   = 3'd1,
    REG_CARE_MASK      = 3'd2,
    REG_PATTERN_LENGTH = 3'd3,
    REG_REGION_BASE    = 3'd4
  } reg_index_t;

  // Signature setup seen by every cell; len is already clamped to 1..MAX
  typedef struct packed {
    logic [SIG_BITS-1:0]  pattern;
    logic [SIG_BYTES-1:0] care;
    logic [LEN_BITS-1:0]  len;
  } sig_cfg_t;

  // Result item, packed so that found sits in bit 0
  typedef struct packed {
    logic [RES_DATA_BITS-ADDR_BITS-3:0] pad;
    logic                               several_matches;
    logic [ADDR_BITS-1:0]               first_match_address;
    logic                               found;
  } result_t;

  // Mismatch of the byte steps places back against its signature position.
  // Position len-1-steps compares with it; distances beyond the length never miss.
  function automatic logic pos_miss(input logic [7:0] b, input logic [LEN_BITS-1:0] steps,
                                    input sig_cfg_t cfg);
    logic [LEN_BITS-1:0] p;
    logic                active;
    p      = cfg.len - 5'd1 - steps;
    active = (steps < cfg.len);
    return active && cfg.care[p[3:0]] && (b != cfg.pattern[p[3:0]*8 +: 8]);
  endfunction

endpackage

FILE: rtl/core/wbss_cell.sv
// One window cell: holds the byte DIST steps back and checks it against
// its signature position. Depends on wbss_pkg.
module wbss_cell
  import wbss_pkg::*;
#(
  parameter int DIST = 1
) (
  input  logic     clk,
  input  logic     shift,
  input  logic [7:0] byte_in,
  input  sig_cfg_t cfg,
  output logic [7:0] byte_out,
  output logic     miss
);

  logic [7:0] win_byte;

  // Shift register stage, moves one place per accepted item
  always_ff @(posedge clk) begin
    if (shift) begin
      win_byte <= byte_in;
    end
  end

  assign byte_out = win_byte;
  assign miss     = pos_miss(win_byte, LEN_BITS'(DIST), cfg);

endmodule

FILE: rtl/core/wbss_out.sv
// Result output register with one skid slot, so scanning goes on while a
// result waits downstream. Depends on wbss_pkg.
module wbss_out
  import wbss_pkg::*;
(
  input  logic                     clk,
  input  logic                     rst,
  input  logic                     load,
  input  result_t                  load_res,
  input  logic                     m_tready,
  output logic                     m_tvalid,
  output logic [RES_DATA_BITS-1:0] m_tdata,
  output logic                     full
);

  logic    out_valid;
  logic    skid_valid;
  result_t out_res;
  result_t skid_res;
  logic    take;

  assign take = out_valid & m_tready;

  // Control: load goes to the output slot when it frees, else to the skid slot
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid  <= 1'b0;
      skid_valid <= 1'b0;
    end else if (load) begin
      if (!out_valid || take) begin
        out_valid <= 1'b1;
      end else begin
        skid_valid <= 1'b1;
      end
    end else if (take) begin
      if (skid_valid) begin
        skid_valid <= 1'b0;
      end else begin
        out_valid <= 1'b0;
      end
    end
  end

  // Payload
  always_ff @(posedge clk) begin
    if (load) begin
      if (!out_valid || take) begin
        out_res <= load_res;
      end else begin
        skid_res <= load_res;
      end
    end else if (take && skid_valid) begin
      out_res <= skid_res;
    end
  end

  assign m_tvalid = out_valid;
  assign m_tdata  = out_res;
  assign full     = skid_valid;

endmodule

FILE: rtl/core/wildcard_byte_signature_scan.sv
// Top level of the wildcard byte signature scanner: byte window cell chain,
// match bookkeeping and result queue. Depends on wbss_pkg, wbss_cell, wbss_out.
//
//  channel   dir  signals                           contents
//  s_*       in   s_tvalid s_tready s_tdata s_tlast region bytes
//  m_*       out  m_tvalid m_tready m_tdata         one result per region
//  cfg_*     in   cfg_valid cfg_ready cfg_index/data register writes
//
// One byte per cycle; every window position is compared in the same cycle
// the byte arrives, the incoming byte directly and each earlier one by its cell.
// A result is loaded on the region's last byte; with the output register and
// its skid slot both full, s_tready drops until it is taken. Synchronous reset
// clears counters, match flags, queue, pattern, base; care to ones, length 1.
module wildcard_byte_signature_scan
  import wbss_pkg::*;
#(
  parameter int MAX_PATTERN = DEF_MAX_PATTERN,
  parameter int OFFSET_BITS = DEF_OFFSET_BITS
) (
  input  logic                     clk,
  input  logic                     rst,
  // slave: [7:0] data_byte
  input  logic                     s_tvalid,
  output logic                     s_tready,
  input  logic [7:0]               s_tdata,
  input  logic                     s_tlast,
  // master: [0] found, [64:1] first_match_address, [65] several_matches
  output logic                     m_tvalid,
  input  logic                     m_tready,
  output logic [RES_DATA_BITS-1:0] m_tdata,
  // configuration writes
  input  logic                     cfg_valid,
  output logic                     cfg_ready,
  input  logic [2:0]               cfg_index,
  input  logic [63:0]              cfg_data
);

  localparam logic [OFFSET_BITS-1:0] COUNT_MAX = {OFFSET_BITS{1'b1}};

  // Configuration registers
  logic [63:0]          pattern_low;
  logic [63:0]          pattern_high;
  logic [SIG_BYTES-1:0] care_mask;
  logic [LEN_BITS-1:0]  pattern_length;
  logic [63:0]          region_base;

  // Scan state
  logic [OFFSET_BITS-1:0] bytes_seen;
  logic                   match_seen;
  logic [OFFSET_BITS-1:0] first_offset;
  logic                   more_than_one;

  sig_cfg_t               cfg;
  logic [LEN_BITS-1:0]    len_used;
  logic [7:0]             chain [MAX_PATTERN];
  logic [MAX_PATTERN-1:0] miss;
  logic                   accept;
  logic                   hit;
  logic [OFFSET_BITS-1:0] need;
  logic [OFFSET_BITS-1:0] cur_offset;
  logic [OFFSET_BITS-1:0] res_offset;
  logic                   out_full;
  result_t                res;

  assign cfg_ready = 1'b1;

  // Register writes
  always_ff @(posedge clk) begin
    if (rst) begin
      pattern_low    <= '0;
      pattern_high   <= '0;
      care_mask      <= '1;
      pattern_length <= LEN_BITS'(1);
      region_base    <= '0;
    end else if (cfg_valid) begin
      unique case (cfg_index)
        REG_PATTERN_LOW:    pattern_low    <= cfg_data;
        REG_PATTERN_HIGH:   pattern_high   <= cfg_data;
        REG_CARE_MASK:      care_mask      <= cfg_data[SIG_BYTES-1:0];
        REG_PATTERN_LENGTH: pattern_length <= cfg_data[LEN_BITS-1:0];
        REG_REGION_BASE:    region_base    <= cfg_data;
        default: ;
      endcase
    end
  end

  // Length in use: zero acts as one, above the maximum acts as the maximum
  always_comb begin
    if (pattern_length == '0) begin
      len_used = LEN_BITS'(1);
    end else if (pattern_length > LEN_BITS'(MAX_PATTERN)) begin
      len_used = LEN_BITS'(MAX_PATTERN);
    end else begin
      len_used = pattern_length;
    end
  end

  assign cfg.pattern = {pattern_high, pattern_low};
  assign cfg.care    = care_mask;
  assign cfg.len     = len_used;

  assign s_tready = ~out_full;
  assign accept   = s_tvalid & s_tready;

  // Distance zero is the incoming byte itself
  assign chain[0] = s_tdata;
  assign miss[0]  = pos_miss(s_tdata, LEN_BITS'(0), cfg);

  // Cell chain for distances 1 .. MAX_PATTERN-1
  for (genvar k = 1; k < MAX_PATTERN; k++) begin : g_cell
    wbss_cell #(
      .DIST(k)
    ) u_cell (
      .clk     (clk),
      .shift   (accept),
      .byte_in (chain[k-1]),
      .cfg     (cfg),
      .byte_out(chain[k]),
      .miss    (miss[k])
    );
  end

  // Match needs len-1 earlier bytes of this region
  assign need       = OFFSET_BITS'(len_used - LEN_BITS'(1));
  assign hit        = (bytes_seen >= need) && (miss == '0);
  assign cur_offset = bytes_seen - need;

  // Scan state update
  always_ff @(posedge clk) begin
    if (rst) begin
      bytes_seen    <= '0;
      match_seen    <= 1'b0;
      first_offset  <= '0;
      more_than_one <= 1'b0;
    end else if (accept) begin
      if (s_tlast) begin
        bytes_seen    <= '0;
        match_seen    <= 1'b0;
        first_offset  <= '0;
        more_than_one <= 1'b0;
      end else begin
        if (bytes_seen != COUNT_MAX) begin
          bytes_seen <= bytes_seen + OFFSET_BITS'(1);
        end
        if (hit) begin
          if (match_seen) begin
            more_than_one <= 1'b1;
          end else begin
            match_seen   <= 1'b1;
            first_offset <= cur_offset;
          end
        end
      end
    end
  end

  // Result of the region, including this last byte
  assign res_offset = match_seen ? first_offset : cur_offset;

  always_comb begin
    res                 = '0;
    res.found           = match_seen | hit;
    res.several_matches = more_than_one | (match_seen & hit);
    res.first_match_address = (match_seen | hit) ?
                              region_base + ADDR_BITS'(res_offset) : '0;
  end

  wbss_out u_out (
    .clk     (clk),
    .rst     (rst),
    .load    (accept & s_tlast),
    .load_res(res),
    .m_tready(m_tready),
    .m_tvalid(m_tvalid),
    .m_tdata (m_tdata),
    .full    (out_full)
  );

endmodule

FILE: bench/tb_wildcard_byte_signature_scan.sv
// Self-checking bench for wildcard_byte_signature_scan: a directed table, then
// random regions with embedded signatures, checked against an in-bench scanner.
// Depends on wbss_pkg and the scanner RTL.
module tb_wildcard_byte_signature_scan;
  import wbss_pkg::*;

  localparam int          SETTLE       = 8;
  localparam int          QUIET_LIMIT  = 2000;
  localparam int          RANDOM_ITEMS = 1730;
  localparam int          ROWS         = 28;
  localparam logic [2:0]  REG_UNUSED   = 3'd7;
  localparam logic [63:0] ALL_ONES     = 64'hFFFF_FFFF_FFFF_FFFF;

  typedef struct packed {
    logic        found;
    logic [63:0] addr;
    logic        several;
  } scan_result_t;

  typedef enum logic {ROW_BYTE, ROW_REG} row_kind_t;

  typedef struct packed {
    row_kind_t    kind;
    logic [2:0]   idx;
    logic [63:0]  value;
    logic [7:0]   data;
    logic         last;
    logic         typed;
    scan_result_t want;
  } plan_row_t;

  typedef struct packed {
    logic         typed;
    scan_result_t res;
  } pinned_t;

  logic                     clk;
  logic                     rst       = 1'b1;
  logic                     s_tvalid  = 1'b0;
  logic                     s_tready;
  logic [7:0]               s_tdata   = '0;   // [7:0] data_byte
  logic                     s_tlast   = 1'b0;
  logic                     m_tvalid;
  logic                     m_tready  = 1'b0;
  logic [RES_DATA_BITS-1:0] m_tdata;          // [0] found, [64:1] address, [65] several
  logic                     cfg_valid = 1'b0;
  logic                     cfg_ready;
  logic [2:0]               cfg_index = '0;
  logic [63:0]              cfg_data  = '0;

  wildcard_byte_signature_scan DUT (
    .clk, .rst,
    .s_tvalid, .s_tready, .s_tdata, .s_tlast,
    .m_tvalid, .m_tready, .m_tdata,
    .cfg_valid, .cfg_ready, .cfg_index, .cfg_data
  );

  always begin
    clk = 1'b0;
    #4;
    clk = 1'b1;
    #4;
  end

  // Register copies, reset values
  logic [63:0] sig_lo   = '0;
  logic [63:0] sig_hi   = '0;
  logic [15:0] care     = 16'hFFFF;
  logic [4:0]  len_reg  = 5'd1;
  logic [63:0] base     = '0;

  // Scan state
  logic [7:0]  recent [16];
  logic [31:0] taken     = '0;
  logic        hit_any   = 1'b0;
  logic [31:0] first_off = '0;
  logic        hit_twice = 1'b0;

  scan_result_t expected_q [$];
  pinned_t      table_results [$];
  int           errors       = 0;
  int           regions_sent = 0;
  int           results_seen = 0;
  int           items_sent   = 0;
  int           burst_left   = 0;
  int           quiet        = 0;

  initial foreach (recent[k]) recent[k] = 8'h00;

  // Directed stimulus; typed results only where obvious
  plan_row_t plan [ROWS] = '{
    // reset setup: one position, byte 0x00 must equal
    '{ROW_BYTE, 3'd0, 64'd0, 8'h00, 1'b1, 1'b1, '{1'b1, 64'd0, 1'b0}},
    '{ROW_BYTE, 3'd0, 64'd0, 8'hFF, 1'b1, 1'b1, '{1'b0, 64'd0, 1'b0}},
    '{ROW_BYTE, 3'd0, 64'd0, 8'h00, 1'b0, 1'b0, '0},
    '{ROW_BYTE, 3'd0, 64'd0, 8'h00, 1'b1, 1'b1, '{1'b1, 64'd0, 1'b1}},
    // leading wildcard then 0xCD, base at the top of the address space
    '{ROW_REG, REG_REGION_BASE, ALL_ONES, 8'h00, 1'b0, 1'b0, '0},
    '{ROW_REG, REG_PATTERN_LOW, 64'h0123_4567_89AB_CDEF, 8'h00, 1'b0, 1'b0, '0},
    '{ROW_REG, REG_CARE_MASK, 64'h0000_0000_0000_0002, 8'h00, 1'b0, 1'b0, '0},
    '{ROW_REG, REG_PATTERN_LENGTH, 64'd2, 8'h00, 1'b0, 1'b0, '0},
    // wildcard would fall before the region start
    '{ROW_BYTE, 3'd0, 64'd0, 8'hCD, 1'b1, 1'b1, '{1'b0, 64'd0, 1'b0}},
    '{ROW_BYTE, 3'd0, 64'd0, 8'h00, 1'b0, 1'b0, '0},
    '{ROW_BYTE, 3'd0, 64'd0, 8'hCD, 1'b1, 1'b1, '{1'b1, ALL_ONES, 1'b0}},
    // address wraps past the top
    '{ROW_BYTE, 3'd0, 64'd0, 8'h11, 1'b0, 1'b0, '0},
    '{ROW_BYTE, 3'd0, 64'd0, 8'h22, 1'b0, 1'b0, '0},
    '{ROW_BYTE, 3'd0, 64'd0, 8'hCD, 1'b1, 1'b0, '0},
    // length 0 acts as 1, all wildcards: every byte matches
    '{ROW_REG, REG_PATTERN_LENGTH, 64'd0, 8'h00, 1'b0, 1'b0, '0},
    '{ROW_REG, REG_CARE_MASK, 64'd0, 8'h00, 1'b0, 1'b0, '0},
    '{ROW_BYTE, 3'd0, 64'd0, 8'h5A, 1'b0, 1'b0, '0},
    '{ROW_BYTE, 3'd0, 64'd0, 8'hA5, 1'b1, 1'b0, '0},
    // signature byte 0x80 against bytes on both sides of it
    '{ROW_REG, REG_PATTERN_LOW, 64'hFFFF_FFFF_FFFF_FF80, 8'h00, 1'b0, 1'b0, '0},
    '{ROW_REG, REG_CARE_MASK, ALL_ONES, 8'h00, 1'b0, 1'b0, '0},
    '{ROW_REG, REG_UNUSED, ALL_ONES, 8'h00, 1'b0, 1'b0, '0},
    '{ROW_BYTE, 3'd0, 64'd0, 8'h7F, 1'b0, 1'b0, '0},
    '{ROW_BYTE, 3'd0, 64'd0, 8'h80, 1'b0, 1'b0, '0},
    '{ROW_BYTE, 3'd0, 64'd0, 8'hFF, 1'b1, 1'b0, '0},
    // oversized length clamps to 16; region too short to hold it
    '{ROW_REG, REG_PATTERN_HIGH, ALL_ONES, 8'h00, 1'b0, 1'b0, '0},
    '{ROW_REG, REG_PATTERN_LENGTH, ALL_ONES, 8'h00, 1'b0, 1'b0, '0},
    '{ROW_BYTE, 3'd0, 64'd0, 8'h80, 1'b0, 1'b0, '0},
    '{ROW_BYTE, 3'd0, 64'd0, 8'hFF, 1'b1, 1'b0, '0}
  };

  // Positions in use after clamping
  function automatic int span();
    int n;
    n = len_reg;
    if (n == 0) n = 1;
    if (n > 16) n = 16;
    return n;
  endfunction

  function automatic logic [7:0] sig_at(input int i);
    return (i < 8) ? sig_lo[8*i +: 8] : sig_hi[8*(i-8) +: 8];
  endfunction

  // Take one byte; returns 1 with the region result on its last byte
  function automatic logic scan_byte(input logic [7:0] cur, input logic last,
                                     output scan_result_t res);
    int         n;
    int         d;
    logic       hit;
    logic [7:0] back;
    n   = span();
    res = '0;
    if (taken >= 32'(n - 1)) begin
      hit = 1'b1;
      for (int i = 0; i < n; i++) begin
        d    = n - 1 - i;
        back = (d == 0) ? cur : recent[d-1];
        if (care[i] && back != sig_at(i)) hit = 1'b0;
      end
      if (hit && hit_any) begin
        hit_twice = 1'b1;
      end else if (hit) begin
        hit_any   = 1'b1;
        first_off = taken - 32'(n - 1);
      end
    end
    for (int k = 15; k > 0; k--) recent[k] = recent[k-1];
    recent[0] = cur;
    if (taken != '1) taken++;
    if (!last) return 1'b0;
    res.found   = hit_any;
    res.addr    = hit_any ? base + {32'd0, first_off} : 64'd0;
    res.several = hit_twice;
    foreach (recent[k]) recent[k] = 8'h00;
    taken     = '0;
    hit_any   = 1'b0;
    first_off = '0;
    hit_twice = 1'b0;
    return 1'b1;
  endfunction

  task automatic report_mismatch(input string what, input logic [63:0] got,
                                 input logic [63:0] want);
    $display("mismatch %s: got %h want %h at result %0d", what, got, want, results_seen);
    errors++;
  endtask

  // Track register writes, predict on accepted items, check results in order
  always @(posedge clk) begin : track
    scan_result_t r;
    scan_result_t want;
    if (!rst) begin
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          REG_PATTERN_LOW:    sig_lo  = cfg_data;
          REG_PATTERN_HIGH:   sig_hi  = cfg_data;
          REG_CARE_MASK:      care    = cfg_data[15:0];
          REG_PATTERN_LENGTH: len_reg = cfg_data[4:0];
          REG_REGION_BASE:    base    = cfg_data;
          default: ;
        endcase
      end
      if (s_tvalid && s_tready && scan_byte(s_tdata, s_tlast, r)) begin
        if (table_results.size() != 0) begin
          if (table_results[0].typed) r = table_results[0].res;
          void'(table_results.pop_front());
        end
        expected_q.push_back(r);
      end
      if (m_tvalid && m_tready) begin
        results_seen++;
        if (expected_q.size() == 0) begin
          report_mismatch("result with none expected", m_tdata[64:1], 64'd0);
        end else begin
          want = expected_q.pop_front();
          if (m_tdata[0] !== want.found)
            report_mismatch("found", 64'(m_tdata[0]), 64'(want.found));
          if (m_tdata[64:1] !== want.addr)
            report_mismatch("first_match_address", m_tdata[64:1], want.addr);
          if (m_tdata[65] !== want.several)
            report_mismatch("several_matches", 64'(m_tdata[65]), 64'(want.several));
        end
      end
    end
  end

  // Receiver stalls: always ready, light and heavy random, then long holds
  logic [9:0] rx_cyc  = '0;
  int         rx_hold = 0;
  always @(posedge clk) begin
    rx_cyc <= rx_cyc + 10'd1;
    case (rx_cyc[9:8])
      2'd0: m_tready <= 1'b1;
      2'd1: m_tready <= ($urandom_range(0, 3) != 0);
      2'd2: m_tready <= ($urandom_range(0, 1) != 0);
      default: begin
        if (rx_hold == 0) begin
          m_tready <= !m_tready;
          rx_hold  <= m_tready ? $urandom_range(0, 30) : $urandom_range(0, 6);
        end else begin
          rx_hold <= rx_hold - 1;
        end
      end
    endcase
  end

  // No item, write or result moving for too long ends the run
  always @(posedge clk) begin
    if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || (cfg_valid && cfg_ready))
      quiet <= 0;
    else
      quiet <= quiet + 1;
    if (quiet == QUIET_LIMIT) begin
      $display("FAIL wildcard_byte_signature_scan");
      $finish;
    end
  end

  // One byte; sender bursts with random gaps between them
  task automatic send_item(input logic [7:0] b, input logic last);
    s_tvalid <= 1'b1;
    s_tdata  <= b;
    s_tlast  <= last;
    do @(posedge clk); while (!s_tready);
    items_sent++;
    if (last) regions_sent++;
    if (burst_left == 0) begin
      s_tvalid <= 1'b0;
      repeat ($urandom_range(1, 6)) @(posedge clk);
      burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(40, 120) : $urandom_range(1, 12);
    end else begin
      burst_left--;
    end
  endtask

  // Register write; caller drops cfg_valid after the last one of a batch
  task automatic load_reg(input logic [2:0] idx, input logic [63:0] value);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= value;
    do @(posedge clk); while (!cfg_ready);
  endtask

  // Hold the sender until every result is in, then let the pipe settle
  task automatic wait_idle();
    s_tvalid <= 1'b0;
    while (results_seen != regions_sent) @(posedge clk);
    repeat (SETTLE) @(posedge clk);
  endtask

  // One region: noise, full signature copies and broken prefixes
  task automatic run_region();
    logic [7:0] bytes [$];
    int rlen;
    int n;
    int sel;
    int cut;
    rlen = ($urandom_range(0, 9) == 0) ? $urandom_range(25, 64) : $urandom_range(1, 24);
    n    = span();
    while (bytes.size() < rlen) begin
      sel = $urandom_range(0, 7);
      cut = (sel == 3) ? $urandom_range(1, n) : n;
      if (sel <= 3) begin
        for (int k = 0; k < cut; k++)
          bytes.push_back(care[k] ? sig_at(k) : 8'($urandom));
      end else if (sel <= 5) begin
        bytes.push_back(sig_at($urandom_range(0, n - 1)));
      end else begin
        bytes.push_back(8'($urandom));
      end
    end
    while (bytes.size() > rlen) void'(bytes.pop_back());
    foreach (bytes[k]) send_item(bytes[k], k == rlen - 1);
  endtask

  initial begin : stimulus
    int          start;
    int          goal;
    logic [4:0]  len5;
    logic [63:0] care_word;
    logic [63:0] base_word;
    repeat (11) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Directed table
    for (int r = 0; r < ROWS; r++) begin
      if (plan[r].kind == ROW_REG) begin
        if (r > 0 && plan[r-1].kind == ROW_BYTE) wait_idle();
        load_reg(plan[r].idx, plan[r].value);
      end else begin
        if (r > 0 && plan[r-1].kind == ROW_REG) cfg_valid <= 1'b0;
        if (plan[r].last) table_results.push_back('{plan[r].typed, plan[r].want});
        send_item(plan[r].data, plan[r].last);
      end
    end

    // Random phases, each with a fresh setup loaded while idle
    start = items_sent;
    for (int p = 0; items_sent - start < RANDOM_ITEMS; p++) begin
      wait_idle();
      case (p)
        0: begin len5 = 5'd16; care_word = ALL_ONES;           base_word = 64'd0;    end
        1: begin len5 = 5'd1;  care_word = 64'd0;              base_word = ALL_ONES; end
        2: begin len5 = 5'd16; care_word = {{48{1'b1}}, 16'h0}; base_word = ALL_ONES; end
        default: begin
          case ($urandom_range(0, 9))
            0:       len5 = 5'd0;
            1:       len5 = 5'($urandom_range(17, 31));
            2:       len5 = 5'd16;
            default: len5 = 5'($urandom_range(1, 16));
          endcase
          case ($urandom_range(0, 5))
            0:       care_word = ALL_ONES;
            1:       care_word = 64'd0;
            2:       care_word = 64'd1 << $urandom_range(0, 15);
            default: care_word = {$urandom, $urandom};
          endcase
          case ($urandom_range(0, 3))
            0:       base_word = 64'd0;
            1:       base_word = ALL_ONES - 64'($urandom_range(0, 40));
            default: base_word = {$urandom, $urandom};
          endcase
        end
      endcase
      load_reg(REG_PATTERN_LOW, {$urandom, $urandom});
      load_reg(REG_PATTERN_HIGH, {$urandom, $urandom});
      load_reg(REG_CARE_MASK, care_word);
      load_reg(REG_PATTERN_LENGTH, {59'($urandom), len5});
      load_reg(REG_REGION_BASE, base_word);
      if ($urandom_range(0, 3) == 0) load_reg(REG_UNUSED, {$urandom, $urandom});
      cfg_valid <= 1'b0;
      goal = items_sent + $urandom_range(60, 200);
      if (goal > start + RANDOM_ITEMS) goal = start + RANDOM_ITEMS;
      while (items_sent < goal) run_region();
    end

    wait_idle();
    if (expected_q.size() != 0)
      report_mismatch("results never came", 64'(expected_q.size()), 64'd0);
    if (errors == 0) begin
      $display("PASS wildcard_byte_signature_scan");
    end else begin
      $display("FAIL wildcard_byte_signature_scan");
    end
    $finish;
  end

endmodule
